// ===== design/ttdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttdt_pkg: shared types and constants of the task dispatch table
// Slot record, result record, command and status codes, and derived widths.
// ----------------------------------------------------------------------------
package ttdt_pkg;

  // Number of task slots and the widths that follow from it.
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Command codes carried in the mode field.
  localparam logic [2:0] MODE_CREATE   = 3'd0;
  localparam logic [2:0] MODE_DELETE   = 3'd1;
  localparam logic [2:0] MODE_SUSPEND  = 3'd2;
  localparam logic [2:0] MODE_RESUME   = 3'd3;
  localparam logic [2:0] MODE_TICK     = 3'd4;
  localparam logic [2:0] MODE_DISPATCH = 3'd5;
  localparam logic [2:0] MODE_READ     = 3'd6;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NOTHING   = 3'd4;

  // Contents of one slot.
  typedef struct packed {
    logic        used;
    logic [15:0] handle;
    logic        held;
    logic [15:0] countdown;
    logic [15:0] period;
    logic [7:0]  pending;
    logic [31:0] last_time;
    logic [31:0] interval;
  } slot_t;

  // Command applied to the slot at the tail of the ring.
  typedef struct packed {
    logic [2:0]  mode;
    logic        hit;
    logic        take;
    logic [15:0] handle;
    logic [15:0] start_delay;
    logic [15:0] period;
    logic [31:0] now;
    logic [7:0]  limit;
  } slot_cmd_t;

  // One buffered result, without the task count and last flag.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [15:0] handle;
    logic [31:0] interval;
  } result_t;

endpackage

// ===== design/ttdt_cell.sv =====
// ----------------------------------------------------------------------------
// ttdt_cell: one storage cell of the slot ring
// Holds one slot record and takes its neighbour's record when the ring turns.
// ----------------------------------------------------------------------------
module ttdt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  ttdt_pkg::slot_t d,
  output ttdt_pkg::slot_t q
);

  // The ring turns one place per cycle during a walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== design/ttdt_slot_op.sv =====
// ----------------------------------------------------------------------------
// ttdt_slot_op: per-slot command logic
// Applies the current command to the slot leaving the tail of the ring.
// ----------------------------------------------------------------------------
module ttdt_slot_op (
  input  ttdt_pkg::slot_cmd_t cmd,
  input  ttdt_pkg::slot_t     cur,
  output ttdt_pkg::slot_t     upd,
  output logic                emit,
  output logic                freed,
  output logic [31:0]         interval
);

  logic active;

  assign active   = cur.used && !cur.held;
  assign interval = cmd.now - cur.last_time;

  // Next contents of the slot for each command.
  always_comb begin
    upd   = cur;
    emit  = 1'b0;
    freed = 1'b0;
    case (cmd.mode)
      ttdt_pkg::MODE_CREATE: begin
        if (cmd.take) begin
          upd           = '0;
          upd.used      = 1'b1;
          upd.handle    = cmd.handle;
          upd.countdown = cmd.start_delay;
          upd.period    = cmd.period;
        end
      end
      ttdt_pkg::MODE_DELETE: begin
        if (cmd.hit && cur.used) begin
          upd   = '0;
          freed = 1'b1;
        end
      end
      ttdt_pkg::MODE_SUSPEND: begin
        if (cmd.hit) begin
          upd.held = 1'b1;
        end
      end
      ttdt_pkg::MODE_RESUME: begin
        if (cmd.hit) begin
          upd.held = 1'b0;
        end
      end
      ttdt_pkg::MODE_TICK: begin
        if (active) begin
          if (cur.countdown != 16'd0) begin
            upd.countdown = cur.countdown - 16'd1;
          end else begin
            if (cur.pending < cmd.limit) begin
              upd.pending = cur.pending + 8'd1;
            end
            if (cur.period != 16'd0) begin
              upd.countdown = cur.period - 16'd1;
            end
          end
        end
      end
      ttdt_pkg::MODE_DISPATCH: begin
        if (active && cur.pending != 8'd0) begin
          emit = 1'b1;
          if (cur.period == 16'd0) begin
            upd   = '0;
            freed = 1'b1;
          end else begin
            upd.interval  = interval;
            upd.last_time = cmd.now;
            upd.pending   = cur.pending - 8'd1;
          end
        end
      end
      default: begin
        upd = cur;
      end
    endcase
  end

endmodule

// ===== design/tick_task_dispatch_table.sv =====
// ----------------------------------------------------------------------------
// tick_task_dispatch_table: command-driven table of cooperative task slots
// Slots live in a ring of cells that turns once per command; the tail slot
// is updated on its way round. Results are buffered and then streamed out.
//
//   port group  | direction | transaction
//   s_axis_*    | in        | one command
//   m_axis_*    | out       | one result (tlast on the final one)
//   APB         | in/out    | run_count_limit register, written at addresses 0 to 3
//
// Every command turns the ring once in WALK and passes through FINISH; EMIT
// then sends its results one at a time, closes and returns to IDLE for the
// next command. The ring walk takes every slot through one shared slot
// update unit, so the slots are updated one after another.
// Reset (rst, synchronous) clears every slot and sets the limit to 255.
// A stalled output holds the result; a new command is taken only when idle.
// ----------------------------------------------------------------------------
module tick_task_dispatch_table (
  input  logic        clk,
  input  logic        rst,
  // mode[2:0], task_handle[18:3], start_delay[34:19], period[50:35],
  // slot_index[58:51], now[90:59], zero fill above
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status[2:0], result_slot[10:3], run_handle[26:11], run_interval[58:27],
  // task_total[65:59], zero fill above
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    WALK   = 4'b0010,
    FINISH = 4'b0100,
    EMIT   = 4'b1000
  } state_t;

  state_t                       state;
  logic [7:0]                   limit;
  logic [2:0]                   mode;
  logic [15:0]                  handle;
  logic [15:0]                  start_delay;
  logic [15:0]                  period;
  logic [7:0]                   idx;
  logic [31:0]                  now;
  logic [ttdt_pkg::SLOT_W-1:0]  k;
  logic [ttdt_pkg::CNT_W-1:0]   n;
  logic [ttdt_pkg::CNT_W-1:0]   rd;
  logic                         found;
  logic [7:0]                   found_slot;
  logic [31:0]                  read_iv;
  logic [6:0]                   used_count;
  ttdt_pkg::result_t            queue [ttdt_pkg::SLOTS];
  ttdt_pkg::slot_t              cell_q [ttdt_pkg::SLOTS];
  ttdt_pkg::slot_t              tail_upd;
  ttdt_pkg::slot_cmd_t          cmd;
  logic                         emit;
  logic                         freed;
  logic [31:0]                  iv;
  logic                         walking;
  logic                         in_range;
  logic                         in_accept;
  logic                         out_free;
  logic                         cfg_write;
  ttdt_pkg::result_t            single;

  assign walking       = (state == WALK);
  assign s_axis_tready = (state == IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_range      = idx < 8'(ttdt_pkg::SLOTS);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign pready        = 1'b1;
  assign prdata        = {24'd0, limit};
  assign cfg_write     = psel && penable && pwrite && pready && !paddr[2];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 8'd255;
    end else if (cfg_write) begin
      limit <= pwdata[7:0];
    end
  end

  // Command for the slot at the tail of the ring.
  always_comb begin
    cmd             = '0;
    cmd.mode        = mode;
    cmd.hit         = in_range && (k == idx[ttdt_pkg::SLOT_W-1:0]);
    cmd.take        = (handle != 16'd0) && !found && !cell_q[ttdt_pkg::SLOTS-1].used;
    cmd.handle      = handle;
    cmd.start_delay = start_delay;
    cmd.period      = period;
    cmd.now         = now;
    cmd.limit       = limit;
  end

  ttdt_slot_op u_op (
    .cmd      (cmd),
    .cur      (cell_q[ttdt_pkg::SLOTS-1]),
    .upd      (tail_upd),
    .emit     (emit),
    .freed    (freed),
    .interval (iv)
  );

  // Ring of slot cells: the tail goes through the update unit to the head.
  for (genvar j = 0; j < ttdt_pkg::SLOTS; j++) begin : g_cell
    if (j == 0) begin : g_head
      ttdt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (walking),
        .d     (tail_upd),
        .q     (cell_q[j])
      );
    end else begin : g_body
      ttdt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (walking),
        .d     (cell_q[j-1]),
        .q     (cell_q[j])
      );
    end
  end

  // Single result of every command other than dispatch, and of a dispatch that runs no task.
  always_comb begin
    single = '0;
    case (mode)
      ttdt_pkg::MODE_CREATE: begin
        if (handle == 16'd0) begin
          single.status = ttdt_pkg::ST_INVALID;
        end else if (found) begin
          single.status = ttdt_pkg::ST_OK;
          single.slot   = found_slot;
        end else begin
          single.status = ttdt_pkg::ST_FULL;
        end
      end
      ttdt_pkg::MODE_DELETE: begin
        single.slot = idx;
        if (!in_range) begin
          single.status = ttdt_pkg::ST_INVALID;
        end else if (found) begin
          single.status = ttdt_pkg::ST_OK;
        end else begin
          single.status = ttdt_pkg::ST_NOT_FOUND;
        end
      end
      ttdt_pkg::MODE_SUSPEND, ttdt_pkg::MODE_RESUME: begin
        single.slot   = idx;
        single.status = in_range ? ttdt_pkg::ST_OK : ttdt_pkg::ST_INVALID;
      end
      ttdt_pkg::MODE_READ: begin
        single.slot = idx;
        if (in_range) begin
          single.status   = ttdt_pkg::ST_OK;
          single.interval = read_iv;
        end else begin
          single.status = ttdt_pkg::ST_INVALID;
        end
      end
      ttdt_pkg::MODE_TICK: begin
        single.status = ttdt_pkg::ST_OK;
      end
      ttdt_pkg::MODE_DISPATCH: begin
        single.status = ttdt_pkg::ST_NOTHING;
      end
      default: begin
        single.status = ttdt_pkg::ST_INVALID;
      end
    endcase
  end

  // Result buffer.
  always_ff @(posedge clk) begin
    if (walking && emit) begin
      queue[n[ttdt_pkg::SLOT_W-1:0]] <= '{ttdt_pkg::ST_OK, 8'(k),
                                          cell_q[ttdt_pkg::SLOTS-1].handle, iv};
    end else if (state == FINISH && (mode != ttdt_pkg::MODE_DISPATCH || n == '0)) begin
      queue[0] <= single;
    end
  end

  // Command sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      k             <= '0;
      n             <= '0;
      rd            <= '0;
      found         <= 1'b0;
      used_count    <= 7'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_accept) begin
            mode        <= s_axis_tdata[2:0];
            handle      <= s_axis_tdata[18:3];
            start_delay <= s_axis_tdata[34:19];
            period      <= s_axis_tdata[50:35];
            idx         <= s_axis_tdata[58:51];
            now         <= s_axis_tdata[90:59];
            k           <= '0;
            n           <= '0;
            rd          <= '0;
            found       <= 1'b0;
            state       <= WALK;
          end
        end
        WALK: begin
          if (mode == ttdt_pkg::MODE_CREATE && cmd.take) begin
            found      <= 1'b1;
            found_slot <= 8'(k);
            used_count <= used_count + 7'd1;
          end
          if (freed) begin
            found      <= 1'b1;
            used_count <= used_count - 7'd1;
          end
          if (cmd.hit) begin
            read_iv <= cell_q[ttdt_pkg::SLOTS-1].interval;
          end
          if (emit) begin
            n <= n + 1'b1;
          end
          if (k == ttdt_pkg::SLOT_W'(ttdt_pkg::SLOTS - 1)) begin
            state <= FINISH;
          end else begin
            k <= k + 1'b1;
          end
        end
        FINISH: begin
          if (mode != ttdt_pkg::MODE_DISPATCH || n == '0) begin
            n <= ttdt_pkg::CNT_W'(1);
          end
          state <= EMIT;
        end
        EMIT: begin
          // The output register is reloaded or emptied only when it is free.
          if (out_free) begin
            if (rd != n) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= {6'd0, used_count, queue[rd[ttdt_pkg::SLOT_W-1:0]].interval,
                                queue[rd[ttdt_pkg::SLOT_W-1:0]].handle,
                                queue[rd[ttdt_pkg::SLOT_W-1:0]].slot,
                                queue[rd[ttdt_pkg::SLOT_W-1:0]].status};
              m_axis_tlast  <= (rd + 1'b1 == n);
              rd            <= rd + 1'b1;
            end else begin
              m_axis_tvalid <= 1'b0;
              state         <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
